### src/qcp_pkg.sv
package qcp_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int NUM_LINES      = 15;
    localparam int NUM_EDGES      = 12;

    localparam logic [3:0] CFG_CENTER_X   = 4'd0;
    localparam logic [3:0] CFG_CENTER_Y   = 4'd1;
    localparam logic [3:0] CFG_HALF_SIZE  = 4'd2;
    localparam logic [3:0] CFG_AXIS_SCALE = 4'd3;

    localparam logic [9:0] CENTER_X_RST   = 10'd300;
    localparam logic [9:0] CENTER_Y_RST   = 10'd135;
    localparam logic [7:0] HALF_SIZE_RST  = 8'd42;
    localparam logic [9:0] AXIS_SCALE_RST = 10'd371;

    localparam logic [3:0] LAST_LINE  = 4'd14;
    localparam logic [3:0] FIRST_AXIS = 4'd12;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } quat_item_t;

    typedef struct packed {
        logic [3:0] line_index;
        logic [9:0] start_x;
        logic [9:0] start_y;
        logic [9:0] end_x;
        logic [9:0] end_y;
        logic       last;
    } line_item_t;

    typedef struct packed {
        logic [9:0] center_x;
        logic [9:0] center_y;
        logic [7:0] half_size;
        logic [9:0] axis_scale;
    } cfg_t;

    // conjugated unit quaternion, Q16
    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic signed [17:0] w;
    } unit_quat_t;

    typedef struct packed {
        logic [7:0][9:0] px;
        logic [7:0][9:0] py;
        logic [2:0][9:0] ax;
        logic [2:0][9:0] ay;
        logic [9:0]      cx;
        logic [9:0]      cy;
    } proj_t;

    // divide by 2^sh, truncating toward zero
    function automatic logic signed [40:0] trunc_shr(input logic signed [40:0] v, input int sh);
        logic signed [40:0] bias;
        bias = v[40] ? ((41'sd1 <<< sh) - 41'sd1) : 41'sd0;
        return (v + bias) >>> sh;
    endfunction

    // corner sign bits: 1 means +1
    function automatic logic corner_pos(input logic [2:0] idx, input int axis);
        logic r;
        case (axis)
            0:       r = idx[0] ^ idx[1];
            1:       r = idx[1];
            default: r = idx[2];
        endcase
        return r;
    endfunction

    function automatic logic [2:0] edge_a(input logic [3:0] k);
        logic [2:0] r;
        case (k)
            4'd0:    r = 3'd0;
            4'd1:    r = 3'd1;
            4'd2:    r = 3'd2;
            4'd3:    r = 3'd3;
            4'd4:    r = 3'd4;
            4'd5:    r = 3'd5;
            4'd6:    r = 3'd6;
            4'd7:    r = 3'd7;
            4'd8:    r = 3'd0;
            4'd9:    r = 3'd1;
            4'd10:   r = 3'd2;
            4'd11:   r = 3'd3;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] edge_b(input logic [3:0] k);
        logic [2:0] r;
        case (k)
            4'd0:    r = 3'd1;
            4'd1:    r = 3'd2;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd0;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd6;
            4'd6:    r = 3'd7;
            4'd7:    r = 3'd4;
            4'd8:    r = 3'd4;
            4'd9:    r = 3'd5;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd7;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

### src/qcp_sqrt.sv
module qcp_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [49:0]         rad,
    input  qcp_pkg::quat_item_t in_q,
    input  logic                in_zero,
    output logic                out_valid,
    output logic [24:0]         out_root,
    output qcp_pkg::quat_item_t out_q,
    output logic                out_zero
);
    import qcp_pkg::*;

    localparam int STEPS = 25;

    logic [27:0] rem_reg  [STEPS];
    logic [24:0] root_reg [STEPS];
    logic [49:0] rad_reg  [STEPS];
    quat_item_t  q_reg    [STEPS];
    logic        zero_reg [STEPS];
    logic        v_reg    [STEPS];

    logic [27:0] rem_prev  [STEPS];
    logic [24:0] root_prev [STEPS];
    logic [49:0] rad_prev  [STEPS];
    quat_item_t  q_prev    [STEPS];
    logic        zero_prev [STEPS];
    logic        v_prev    [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            logic [27:0] r2;
            logic [27:0] trial;

            if (k == 0)
            begin : g_first
                assign rem_prev[k]  = '0;
                assign root_prev[k] = '0;
                assign rad_prev[k]  = rad;
                assign q_prev[k]    = in_q;
                assign zero_prev[k] = in_zero;
                assign v_prev[k]    = in_valid;
            end
            else
            begin : g_next
                assign rem_prev[k]  = rem_reg[k-1];
                assign root_prev[k] = root_reg[k-1];
                assign rad_prev[k]  = rad_reg[k-1];
                assign q_prev[k]    = q_reg[k-1];
                assign zero_prev[k] = zero_reg[k-1];
                assign v_prev[k]    = v_reg[k-1];
            end

            assign r2    = {rem_prev[k][25:0], rad_prev[k][49:48]};
            assign trial = {1'b0, root_prev[k], 2'b01};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_prev[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (r2 >= trial)
                    begin
                        rem_reg[k]  <= r2 - trial;
                        root_reg[k] <= {root_prev[k][23:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k]  <= r2;
                        root_reg[k] <= {root_prev[k][23:0], 1'b0};
                    end
                    rad_reg[k]  <= {rad_prev[k][47:0], 2'b00};
                    q_reg[k]    <= q_prev[k];
                    zero_reg[k] <= zero_prev[k];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];
    assign out_q     = q_reg[STEPS-1];
    assign out_zero  = zero_reg[STEPS-1];

endmodule

### src/qcp_div.sv
module qcp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [24:0]         divisor,
    input  qcp_pkg::quat_item_t in_q,
    input  logic                in_zero,
    output logic                out_valid,
    output logic [3:0][16:0]    out_quo,
    output logic [3:0]          out_neg,
    output logic                out_zero
);
    import qcp_pkg::*;

    localparam int STEPS = 17;
    localparam int LANES = 4;

    logic [LANES-1:0][25:0] rem_reg  [STEPS];
    logic [LANES-1:0][16:0] quo_reg  [STEPS];
    logic [24:0]            n_reg    [STEPS];
    logic [LANES-1:0]       neg_reg  [STEPS];
    logic                   zero_reg [STEPS];
    logic                   v_reg    [STEPS];

    logic [LANES-1:0][25:0] rem_prev  [STEPS];
    logic [LANES-1:0][16:0] quo_prev  [STEPS];
    logic [24:0]            n_prev    [STEPS];
    logic [LANES-1:0]       neg_prev  [STEPS];
    logic                   zero_prev [STEPS];
    logic                   v_prev    [STEPS];

    logic signed [15:0]     comp [LANES];
    logic [LANES-1:0][25:0] rem_init;
    logic [LANES-1:0]       neg_init;

    assign comp[0] = in_q.quat_x;
    assign comp[1] = in_q.quat_y;
    assign comp[2] = in_q.quat_z;
    assign comp[3] = in_q.quat_w;

    // |q| * 2^24 / n: the low dividend bits are zero, so only |q| << 7 is preloaded
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [16:0] mag;
            mag = comp[l][15] ? 17'(-$signed({comp[l][15], comp[l]}))
                              : {1'b0, comp[l]};
            rem_init[l] = {2'b00, mag, 7'd0};
            neg_init[l] = comp[l][15];
        end
    end

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            logic [LANES-1:0][25:0] rem_new;
            logic [LANES-1:0][16:0] quo_new;

            if (k == 0)
            begin : g_first
                assign rem_prev[k]  = rem_init;
                assign quo_prev[k]  = '0;
                assign n_prev[k]    = divisor;
                assign neg_prev[k]  = neg_init;
                assign zero_prev[k] = in_zero;
                assign v_prev[k]    = in_valid;
            end
            else
            begin : g_next
                assign rem_prev[k]  = rem_reg[k-1];
                assign quo_prev[k]  = quo_reg[k-1];
                assign n_prev[k]    = n_reg[k-1];
                assign neg_prev[k]  = neg_reg[k-1];
                assign zero_prev[k] = zero_reg[k-1];
                assign v_prev[k]    = v_reg[k-1];
            end

            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    logic [25:0] t;
                    t = {rem_prev[k][l][24:0], 1'b0};
                    if (t >= {1'b0, n_prev[k]})
                    begin
                        rem_new[l] = t - {1'b0, n_prev[k]};
                        quo_new[l] = {quo_prev[k][l][15:0], 1'b1};
                    end
                    else
                    begin
                        rem_new[l] = t;
                        quo_new[l] = {quo_prev[k][l][15:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_prev[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_new;
                    quo_reg[k]  <= quo_new;
                    n_reg[k]    <= n_prev[k];
                    neg_reg[k]  <= neg_prev[k];
                    zero_reg[k] <= zero_prev[k];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[STEPS-1];
    assign out_quo   = quo_reg[STEPS-1];
    assign out_neg   = neg_reg[STEPS-1];
    assign out_zero  = zero_reg[STEPS-1];

endmodule

### src/qcp_norm.sv
module qcp_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  qcp_pkg::quat_item_t in_q,
    output logic                out_valid,
    output qcp_pkg::unit_quat_t out_u
);
    import qcp_pkg::*;

    logic        v0_reg, v1_reg, v2_reg, vu_reg;
    quat_item_t  q0_reg, q1_reg, q2_reg;
    logic [31:0] sq_reg [4];
    logic [32:0] sum_reg;
    logic        zero_reg;
    unit_quat_t  u_reg;

    logic        sq_valid;
    logic [24:0] sq_root;
    quat_item_t  sq_q;
    logic        sq_zero;

    logic             dv_valid;
    logic [3:0][16:0] dv_quo;
    logic [3:0]       dv_neg;
    logic             dv_zero;

    logic [32:0] sum_next;
    unit_quat_t  u_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vu_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            vu_reg <= dv_valid;
        end
    end

    assign sum_next = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]}
                    + {1'b0, sq_reg[2]} + {1'b0, sq_reg[3]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg    <= in_q;
            sq_reg[0] <= 32'(q0_reg.quat_x * q0_reg.quat_x);
            sq_reg[1] <= 32'(q0_reg.quat_y * q0_reg.quat_y);
            sq_reg[2] <= 32'(q0_reg.quat_z * q0_reg.quat_z);
            sq_reg[3] <= 32'(q0_reg.quat_w * q0_reg.quat_w);
            q1_reg    <= q0_reg;
            sum_reg   <= sum_next;
            zero_reg  <= (sum_next == '0);
            q2_reg    <= q1_reg;
            u_reg     <= u_next;
        end
    end

    qcp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v2_reg),
        .rad      ({1'b0, sum_reg, 16'd0}),
        .in_q     (q2_reg),
        .in_zero  (zero_reg),
        .out_valid(sq_valid),
        .out_root (sq_root),
        .out_q    (sq_q),
        .out_zero (sq_zero)
    );

    qcp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sq_valid),
        .divisor  (sq_root),
        .in_q     (sq_q),
        .in_zero  (sq_zero),
        .out_valid(dv_valid),
        .out_quo  (dv_quo),
        .out_neg  (dv_neg),
        .out_zero (dv_zero)
    );

    // conjugate folds into the sign: x, y, z flip, w keeps its sign
    // lanes are x, y, z, w in order 0 to 3
    always_comb
    begin
        logic signed [17:0] mag [4];
        for (int l = 0; l < 4; l++)
        begin
            mag[l] = $signed({1'b0, dv_quo[l]});
        end
        if (dv_zero)
        begin
            u_next.x = '0;
            u_next.y = '0;
            u_next.z = '0;
            u_next.w = 18'sd65536;
        end
        else
        begin
            u_next.x = dv_neg[0] ? mag[0] : -mag[0];
            u_next.y = dv_neg[1] ? mag[1] : -mag[1];
            u_next.z = dv_neg[2] ? mag[2] : -mag[2];
            u_next.w = dv_neg[3] ? -mag[3] : mag[3];
        end
    end

    assign out_valid = vu_reg;
    assign out_u     = u_reg;

endmodule

### src/qcp_proj.sv
module qcp_proj #(
    parameter int COORD_BITS = qcp_pkg::COORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  qcp_pkg::cfg_t       cfg,
    input  logic                in_valid,
    input  qcp_pkg::unit_quat_t in_u,
    output logic                out_valid,
    output qcp_pkg::proj_t      out_p
);
    import qcp_pkg::*;

    localparam logic signed [40:0] MAXV = (41'sd1 <<< COORD_BITS) - 41'sd1;

    function automatic logic [9:0] sat(input logic signed [40:0] v);
        logic signed [40:0] c;
        if (v < 0)
        begin
            c = '0;
        end
        else if (v > MAXV)
        begin
            c = MAXV;
        end
        else
        begin
            c = v;
        end
        return c[9:0];
    endfunction

    logic [4:0] v_reg;

    // stage 1: products
    logic signed [35:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [35:0] wx_reg, wy_reg, wz_reg;
    // stage 2: matrix
    logic signed [19:0] r_reg [3][3];
    logic signed [19:0] r_next [3][3];
    // stage 3: corner sums
    logic signed [21:0] sx_reg [8];
    logic signed [21:0] sy_reg [8];
    logic signed [21:0] sx_next [8];
    logic signed [21:0] sy_next [8];
    logic signed [19:0] ra_reg [3][2];
    logic [17:0]        ashs_reg;
    // stage 4: scaled offsets
    logic signed [30:0] cpx_reg [8];
    logic signed [30:0] cpy_reg [8];
    logic signed [38:0] ap_reg [3][2];
    // stage 5
    proj_t p_reg, p_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    function automatic logic signed [19:0] mterm(input logic signed [35:0] a,
                                                 input logic signed [35:0] b,
                                                 input logic sub, input logic diag);
        logic signed [40:0] s;
        logic signed [40:0] t;
        s = sub ? (41'(a) - 41'(b)) : (41'(a) + 41'(b));
        t = trunc_shr(s <<< 1, 16);
        if (diag)
        begin
            t = 41'sd65536 - t;
        end
        return t[19:0];
    endfunction

    always_comb
    begin
        r_next[0][0] = mterm(yy_reg, zz_reg, 1'b0, 1'b1);
        r_next[0][1] = mterm(xy_reg, wz_reg, 1'b1, 1'b0);
        r_next[0][2] = mterm(xz_reg, wy_reg, 1'b0, 1'b0);
        r_next[1][0] = mterm(xy_reg, wz_reg, 1'b0, 1'b0);
        r_next[1][1] = mterm(xx_reg, zz_reg, 1'b0, 1'b1);
        r_next[1][2] = mterm(yz_reg, wx_reg, 1'b1, 1'b0);
        r_next[2][0] = mterm(xz_reg, wy_reg, 1'b1, 1'b0);
        r_next[2][1] = mterm(yz_reg, wx_reg, 1'b0, 1'b0);
        r_next[2][2] = mterm(xx_reg, yy_reg, 1'b0, 1'b1);
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            logic signed [21:0] ax, ay;
            ax = '0;
            ay = '0;
            for (int j = 0; j < 3; j++)
            begin
                if (corner_pos(3'(i), j))
                begin
                    ax = ax + 22'(r_reg[0][j]);
                    ay = ay + 22'(r_reg[1][j]);
                end
                else
                begin
                    ax = ax - 22'(r_reg[0][j]);
                    ay = ay - 22'(r_reg[1][j]);
                end
            end
            sx_next[i] = ax;
            sy_next[i] = ay;
        end
    end

    always_comb
    begin
        logic signed [40:0] cxs, cys, cxb, cyb;
        cxs = $signed({15'd0, cfg.center_x, 16'd0});
        cys = $signed({15'd0, cfg.center_y, 16'd0});
        cxb = $signed({7'd0, cfg.center_x, 24'd0});
        cyb = $signed({7'd0, cfg.center_y, 24'd0});
        for (int i = 0; i < 8; i++)
        begin
            p_next.px[i] = sat(trunc_shr(cxs + 41'(cpx_reg[i]), 16));
            p_next.py[i] = sat(trunc_shr(cys + 41'(cpy_reg[i]), 16));
        end
        for (int i = 0; i < 3; i++)
        begin
            p_next.ax[i] = sat(trunc_shr(cxb + 41'(ap_reg[i][0]), 24));
            p_next.ay[i] = sat(trunc_shr(cyb + 41'(ap_reg[i][1]), 24));
        end
        p_next.cx = sat($signed({31'd0, cfg.center_x}));
        p_next.cy = sat($signed({31'd0, cfg.center_y}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= in_u.x * in_u.x;
            yy_reg <= in_u.y * in_u.y;
            zz_reg <= in_u.z * in_u.z;
            xy_reg <= in_u.x * in_u.y;
            xz_reg <= in_u.x * in_u.z;
            yz_reg <= in_u.y * in_u.z;
            wx_reg <= in_u.w * in_u.x;
            wy_reg <= in_u.w * in_u.y;
            wz_reg <= in_u.w * in_u.z;

            r_reg <= r_next;

            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            ashs_reg <= 18'(cfg.axis_scale * cfg.half_size);
            for (int i = 0; i < 3; i++)
            begin
                ra_reg[i][0] <= r_reg[i][0];
                ra_reg[i][1] <= r_reg[i][1];
            end

            for (int i = 0; i < 8; i++)
            begin
                cpx_reg[i] <= 31'($signed({1'b0, cfg.half_size}) * sx_reg[i]);
                cpy_reg[i] <= 31'($signed({1'b0, cfg.half_size}) * sy_reg[i]);
            end
            for (int i = 0; i < 3; i++)
            begin
                ap_reg[i][0] <= 39'($signed({1'b0, ashs_reg}) * ra_reg[i][0]);
                ap_reg[i][1] <= 39'($signed({1'b0, ashs_reg}) * ra_reg[i][1]);
            end

            p_reg <= p_next;
        end
    end

    assign out_valid = v_reg[4];
    assign out_p     = p_reg;

endmodule

### src/qcp_seq.sv
module qcp_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  qcp_pkg::proj_t      in_p,
    output logic                ready,
    output logic                line_valid,
    input  logic                line_stall,
    output qcp_pkg::line_item_t line
);
    import qcp_pkg::*;

    proj_t      hold_reg;
    logic       busy_reg;
    logic [3:0] cnt_reg;
    logic       take;
    logic       load;
    logic [1:0] axis;
    logic [2:0] ca, cb;

    assign take  = busy_reg && !line_stall;
    assign ready = !busy_reg || (take && cnt_reg == LAST_LINE);
    assign load  = in_valid && ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (take)
        begin
            busy_reg <= (cnt_reg != LAST_LINE);
            cnt_reg  <= cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= in_p;
        end
    end

    assign axis = 2'(cnt_reg - FIRST_AXIS);
    assign ca   = edge_a(cnt_reg);
    assign cb   = edge_b(cnt_reg);

    always_comb
    begin
        line.line_index = cnt_reg;
        line.last       = (cnt_reg == LAST_LINE);
        if (cnt_reg < FIRST_AXIS)
        begin
            line.start_x = hold_reg.px[ca];
            line.start_y = hold_reg.py[ca];
            line.end_x   = hold_reg.px[cb];
            line.end_y   = hold_reg.py[cb];
        end
        else
        begin
            line.start_x = hold_reg.cx;
            line.start_y = hold_reg.cy;
            line.end_x   = hold_reg.ax[axis];
            line.end_y   = hold_reg.ay[axis];
        end
    end

    assign line_valid = busy_reg;

endmodule

### src/quaternion_cube_projector_core.sv
// Wire-cube projector: each quaternion (signed Q14) is normalized, conjugated,
// turned into a rotation matrix and projected into fifteen lines (twelve cube
// edges, then the X, Y and Z axes from the center), one line per cycle while
// line_stall is low. The sequencer holds one quaternion's lines at a time and
// accepts the next projection as its last line is taken. The delay to the first
// line is set mostly by the bit-per-stage square root (25 stages) and divider
// (17 stages). Quaternions are taken every cycle while the pipeline has room,
// so several can be in flight. Configuration writes are taken at any time and
// should only be made when the block is idle.
module quaternion_cube_projector_core #(
    parameter int COORD_BITS = qcp_pkg::COORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                quat_valid,
    output logic                quat_stall,
    input  qcp_pkg::quat_item_t quat,
    output logic                line_valid,
    input  logic                line_stall,
    output qcp_pkg::line_item_t line,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_index,
    input  logic [9:0]          cfg_data
);
    import qcp_pkg::*;

    cfg_t       cfg_reg;
    logic       en;
    logic       u_valid;
    unit_quat_t u;
    logic       p_valid;
    proj_t      p;
    logic       seq_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x   <= CENTER_X_RST;
            cfg_reg.center_y   <= CENTER_Y_RST;
            cfg_reg.half_size  <= HALF_SIZE_RST;
            cfg_reg.axis_scale <= AXIS_SCALE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CENTER_X:   cfg_reg.center_x   <= cfg_data;
                CFG_CENTER_Y:   cfg_reg.center_y   <= cfg_data;
                CFG_HALF_SIZE:  cfg_reg.half_size  <= cfg_data[7:0];
                CFG_AXIS_SCALE: cfg_reg.axis_scale <= cfg_data;
                default:        ;
            endcase
        end
    end

    // whole pipeline holds while a finished item waits on a busy sequencer
    assign en         = !(p_valid && !seq_ready);
    assign quat_stall = !en;

    qcp_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (quat_valid),
        .in_q     (quat),
        .out_valid(u_valid),
        .out_u    (u)
    );

    qcp_proj #(
        .COORD_BITS(COORD_BITS)
    ) u_proj (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg_reg),
        .in_valid (u_valid),
        .in_u     (u),
        .out_valid(p_valid),
        .out_p    (p)
    );

    qcp_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_p      (p),
        .ready     (seq_ready),
        .line_valid(line_valid),
        .line_stall(line_stall),
        .line      (line)
    );

endmodule
